>>> hdl/hnm_pkg.sv
// shared constants and types for the heightmap normal generator
package hnm_pkg;

  localparam int MaxRowLength = 1024;
  localparam int HeightBits   = 16;
  localparam int AddrW        = $clog2(MaxRowLength);
  localparam int RowW         = 16;
  localparam int RowLenW      = 11;
  localparam int CfgIdxW      = 2;
  localparam int CfgDataW     = 16;
  localparam int CompW        = HeightBits + 3;
  localparam int NormW        = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_ROW_LENGTH = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROW_COUNT  = 2'd1;

  typedef logic signed [HeightBits-1:0] height_t;
  typedef logic signed [CompW-1:0]      comp_t;
  typedef logic signed [NormW-1:0]      norm_t;

  // unnormalized surface vector handed to the normalizer
  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } vec_t;

  // unit normal handed back
  typedef struct packed {
    logic  done;
    norm_t x;
    norm_t y;
    norm_t z;
  } norm_res_t;

endpackage

>>> hdl/hnm_line_buf.sv
// line buffer memory holding the upper and middle rows per column
module hnm_line_buf (
  input  logic                                clk,
  input  logic                                wr_en,
  input  logic [hnm_pkg::AddrW-1:0]           wr_addr,
  input  logic [2*hnm_pkg::HeightBits-1:0]    wr_data,
  input  logic [hnm_pkg::AddrW-1:0]           rd_addr,
  output logic [2*hnm_pkg::HeightBits-1:0]    rd_data
);

  logic [2*hnm_pkg::HeightBits-1:0] mem [0:hnm_pkg::MaxRowLength-1];
  logic [2*hnm_pkg::HeightBits-1:0] rd_data_r;

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/hnm_norm_unit.sv
// iterative normalizer built around one shared 32x32 multiplier
module hnm_norm_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  hnm_pkg::vec_t        vec,
  output hnm_pkg::norm_res_t   res
);

  localparam int CompMagW = hnm_pkg::CompW - 1;

  typedef enum logic [2:0] {N_IDLE, N_SQ, N_ACC, N_D, N_DS, N_CMP} nstate_t;

  nstate_t     state_r;
  logic [14:0] a_r   [0:2];
  logic [29:0] a2_r  [0:2];
  logic        neg_r [0:2];
  logic [31:0] s_r;
  logic [63:0] prod_r;
  logic [1:0]  idx_r;
  logic [3:0]  bit_r;
  logic [14:0] q_r;
  logic        done_r;
  hnm_pkg::norm_t res_r [0:2];

  logic [CompMagW-1:0] mag0, mag1, mag2, m;
  logic [1:0]  sh;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [14:0] t;
  logic [16:0] d;
  logic [15:0] qs;

  // magnitudes and the prescale shift
  always_comb begin
    mag0 = vec.x[hnm_pkg::CompW-1] ? CompMagW'(-vec.x) : vec.x[CompMagW-1:0];
    mag1 = vec.y[hnm_pkg::CompW-1] ? CompMagW'(-vec.y) : vec.y[CompMagW-1:0];
    mag2 = vec.z[hnm_pkg::CompW-1] ? CompMagW'(-vec.z) : vec.z[CompMagW-1:0];
    m = mag0;
    if (mag1 > m) m = mag1;
    if (mag2 > m) m = mag2;
    if (m[CompMagW-1:16] != '0) sh = 2'd2;
    else if (m[15]) sh = 2'd1;
    else sh = 2'd0;
  end

  // trial bit, odd multiplier and the kept quotient for the current digit
  always_comb begin
    t  = q_r | (15'd1 << bit_r);
    d  = {1'b0, t, 1'b0} - 17'd1;
    if (prod_r <= {4'd0, a2_r[idx_r], 30'd0}) qs = {1'b0, t};
    else qs = {1'b0, q_r};
  end

  // shared multiplier operand select
  always_comb begin
    case (state_r)
      N_SQ:    begin mul_a = 32'(a_r[idx_r]); mul_b = 32'(a_r[idx_r]); end
      N_D:     begin mul_a = 32'(d);          mul_b = 32'(d);          end
      N_DS:    begin mul_a = prod_r[31:0];    mul_b = s_r;             end
      default: begin mul_a = '0;              mul_b = '0;              end
    endcase
    mul_p = mul_a * mul_b;
  end

  // sequencer: squares, sum, then a result bit per N_D, N_DS, N_CMP pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            if (m == '0) begin
              res_r[0] <= '0;
              res_r[1] <= 16'sd16384;
              res_r[2] <= '0;
              done_r   <= 1'b1;
            end else begin
              a_r[0]   <= 15'(mag0 >> sh);
              a_r[1]   <= 15'(mag1 >> sh);
              a_r[2]   <= 15'(mag2 >> sh);
              neg_r[0] <= vec.x[hnm_pkg::CompW-1];
              neg_r[1] <= vec.y[hnm_pkg::CompW-1];
              neg_r[2] <= vec.z[hnm_pkg::CompW-1];
              s_r      <= '0;
              idx_r    <= '0;
              state_r  <= N_SQ;
            end
          end
        end
        N_SQ: begin
          prod_r  <= mul_p;
          state_r <= N_ACC;
        end
        N_ACC: begin
          s_r          <= s_r + prod_r[31:0];
          a2_r[idx_r]  <= prod_r[29:0];
          if (idx_r == 2'd2) begin
            idx_r   <= '0;
            bit_r   <= 4'd14;
            q_r     <= '0;
            state_r <= N_D;
          end else begin
            idx_r   <= idx_r + 2'd1;
            state_r <= N_SQ;
          end
        end
        N_D: begin
          prod_r  <= mul_p;
          state_r <= N_DS;
        end
        N_DS: begin
          prod_r  <= mul_p;
          state_r <= N_CMP;
        end
        N_CMP: begin
          if (bit_r == 4'd0) begin
            res_r[idx_r] <= neg_r[idx_r] ? -qs : qs;
            q_r          <= '0;
            bit_r        <= 4'd14;
            if (idx_r == 2'd2) begin
              done_r  <= 1'b1;
              state_r <= N_IDLE;
            end else begin
              idx_r   <= idx_r + 2'd1;
              state_r <= N_D;
            end
          end else begin
            q_r     <= qs[14:0];
            bit_r   <= bit_r - 4'd1;
            state_r <= N_D;
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign res.done = done_r;
  assign res.x    = res_r[0];
  assign res.y    = res_r[1];
  assign res.z    = res_r[2];

endmodule

>>> hdl/heightmap_normal_generator_top.sv
// top level: sample intake, line buffer access, difference setup and result register
// Takes one height sample at a time and releases up to three unit normals for
// it (none for samples of the first row when the frame has more than one row,
// up to three in the last row). After a sample is taken the block reads four
// neighbour words from the line buffer and writes one back, then builds each
// normal on the shared iterative normalizer: the squares and their sum, then
// two multiplies and a compare per result bit over 15 bits for each of the
// three components, with a shortcut when the vector is zero. in_stall stays
// high until all normals of the sample are in the output register. A write to
// either configuration register restarts the frame at row 0, column 0.
module heightmap_normal_generator_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [hnm_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [hnm_pkg::CfgDataW-1:0]     cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [hnm_pkg::HeightBits-1:0] in_height_sample,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [hnm_pkg::AddrW-1:0]        out_column,
  output logic [hnm_pkg::RowW-1:0]         out_row,
  output logic signed [hnm_pkg::NormW-1:0] out_normal_x,
  output logic signed [hnm_pkg::NormW-1:0] out_normal_y,
  output logic signed [hnm_pkg::NormW-1:0] out_normal_z,
  output logic                             out_run_end,
  output logic                             out_frame_end
);

  localparam int AW = hnm_pkg::AddrW;
  localparam int HB = hnm_pkg::HeightBits;
  localparam int RW = hnm_pkg::RowW;
  localparam int LW = hnm_pkg::RowLenW;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_RD3, S_WR, S_PICK, S_NORM, S_OUT
  } state_t;

  state_t            state_r;
  logic [LW-1:0]     row_length_r;
  logic [RW-1:0]     row_count_r;
  logic [AW-1:0]     col_r, cur_c_r;
  logic [RW-1:0]     row_r, cur_r_r;
  hnm_pkg::height_t  h_r, prev_r, old_up_r, old_mid_r, u_cm1_r, m_cp1_r, m_cm2_r;
  logic [1:0]        slot_r;
  logic [AW-1:0]     pc_r;
  logic [RW-1:0]     pr_r;
  logic              run_end_r, frame_end_r;
  logic              out_valid_r;
  logic [AW-1:0]     out_column_r;
  logic [RW-1:0]     out_row_r;
  hnm_pkg::norm_t    out_nx_r, out_ny_r, out_nz_r;
  logic              out_run_end_r, out_frame_end_r;

  logic [LW-1:0]     eff_w;
  logic [RW-1:0]     eff_r;
  logic [LW-1:0]     w_last;
  logic [RW-1:0]     r_last;
  logic              e0, e1, e2, found, last;
  logic [1:0]        sel;
  logic [AW-1:0]     pc;
  logic [RW-1:0]     pr;
  hnm_pkg::height_t  nb_up, nb_left, nb_ctr, nb_right, nb_down;
  logic signed [HB:0] dz, dx;
  logic [1:0]        sz, sx;
  hnm_pkg::vec_t     vec;
  hnm_pkg::norm_res_t nres;
  logic              norm_start;
  logic [AW-1:0]     rd_addr;
  logic [2*HB-1:0]   rd_data;
  logic              wr_en;
  logic [LW:0]       col_inc;
  logic [RW:0]       row_inc;
  logic              out_free;

  // effective grid size
  always_comb begin
    if (row_length_r == '0) eff_w = LW'(1);
    else if (row_length_r > LW'(hnm_pkg::MaxRowLength)) eff_w = LW'(hnm_pkg::MaxRowLength);
    else eff_w = row_length_r;
    eff_r  = (row_count_r == '0) ? RW'(1) : row_count_r;
    w_last = eff_w - LW'(1);
    r_last = eff_r - RW'(1);
  end

  // which normals this sample releases
  always_comb begin
    e0 = (cur_r_r != '0);
    e1 = (cur_r_r == r_last) && (cur_c_r != '0);
    e2 = (cur_r_r == r_last) && ({1'b0, cur_c_r} == w_last);
    found = 1'b1;
    sel   = 2'd0;
    if (slot_r == 2'd0 && e0) sel = 2'd0;
    else if (slot_r <= 2'd1 && e1) sel = 2'd1;
    else if (e2 && slot_r <= 2'd2) sel = 2'd2;
    else found = 1'b0;
    case (sel)
      2'd0:    last = !e1 && !e2;
      2'd1:    last = !e2;
      default: last = 1'b1;
    endcase
  end

  // neighbours of the selected point
  always_comb begin
    case (sel)
      2'd0: begin
        pr = cur_r_r - RW'(1); pc = cur_c_r;
        nb_up = old_up_r; nb_left = u_cm1_r; nb_ctr = old_mid_r;
        nb_right = m_cp1_r; nb_down = h_r;
      end
      2'd1: begin
        pr = cur_r_r; pc = cur_c_r - AW'(1);
        nb_up = u_cm1_r; nb_left = m_cm2_r; nb_ctr = prev_r;
        nb_right = h_r; nb_down = '0;
      end
      default: begin
        pr = cur_r_r; pc = cur_c_r;
        nb_up = old_mid_r; nb_left = prev_r; nb_ctr = h_r;
        nb_right = '0; nb_down = '0;
      end
    endcase
  end

  // one-sided or central differences and the surface vector
  always_comb begin
    if (eff_r == RW'(1)) begin
      sz = 2'd0; dz = '0;
    end else if (pr == '0) begin
      sz = 2'd1; dz = (HB+1)'(nb_down) - (HB+1)'(nb_ctr);
    end else if (pr == r_last) begin
      sz = 2'd1; dz = (HB+1)'(nb_ctr) - (HB+1)'(nb_up);
    end else begin
      sz = 2'd2; dz = (HB+1)'(nb_down) - (HB+1)'(nb_up);
    end
    if (eff_w == LW'(1)) begin
      sx = 2'd0; dx = '0;
    end else if (pc == '0) begin
      sx = 2'd1; dx = (HB+1)'(nb_right) - (HB+1)'(nb_ctr);
    end else if ({1'b0, pc} == w_last) begin
      sx = 2'd1; dx = (HB+1)'(nb_ctr) - (HB+1)'(nb_left);
    end else begin
      sx = 2'd2; dx = (HB+1)'(nb_right) - (HB+1)'(nb_left);
    end
    case (sz)
      2'd0:    vec.x = '0;
      2'd1:    vec.x = -hnm_pkg::CompW'(dx);
      default: vec.x = -(hnm_pkg::CompW'(dx) <<< 1);
    endcase
    case (sx)
      2'd0:    vec.z = '0;
      2'd1:    vec.z = -hnm_pkg::CompW'(dz);
      default: vec.z = -(hnm_pkg::CompW'(dz) <<< 1);
    endcase
    vec.y = hnm_pkg::CompW'({5'd0, sz} * {5'd0, sx}) <<< 8;
  end

  // line buffer address sequence
  always_comb begin
    case (state_r)
      S_RD0:   rd_addr = cur_c_r;
      S_RD1:   rd_addr = cur_c_r - AW'(1);
      S_RD2:   rd_addr = cur_c_r + AW'(1);
      default: rd_addr = cur_c_r - AW'(2);
    endcase
    wr_en      = (state_r == S_WR);
    norm_start = (state_r == S_PICK) && found;
    col_inc    = {1'b0, col_r} + (LW+1)'(1);
    row_inc    = {1'b0, row_r} + (RW+1)'(1);
    out_free   = !out_valid_r || !out_stall;
  end

  hnm_line_buf u_line_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur_c_r),
    .wr_data ({old_mid_r, h_r}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hnm_norm_unit u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vec   (vec),
    .res   (nres)
  );

  // main sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      row_length_r <= LW'(1024);
      row_count_r  <= RW'(1024);
      col_r        <= '0;
      row_r        <= '0;
      prev_r       <= '0;
      slot_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // result beat loads or leaves
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en && (cfg_index == hnm_pkg::CFG_ROW_LENGTH)) begin
        row_length_r <= cfg_data[LW-1:0];
        col_r <= '0;
        row_r <= '0;
      end else if (cfg_wr_en && (cfg_index == hnm_pkg::CFG_ROW_COUNT)) begin
        row_count_r <= cfg_data[RW-1:0];
        col_r <= '0;
        row_r <= '0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            h_r     <= in_height_sample;
            cur_c_r <= col_r;
            cur_r_r <= row_r;
            if (col_inc >= (LW+1)'(eff_w)) begin
              col_r <= '0;
              row_r <= (row_inc >= (RW+1)'(eff_r)) ? '0 : row_inc[RW-1:0];
            end else begin
              col_r <= col_inc[AW-1:0];
            end
            state_r <= S_RD0;
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          old_up_r  <= rd_data[2*HB-1:HB];
          old_mid_r <= rd_data[HB-1:0];
          state_r   <= S_RD2;
        end
        S_RD2: begin
          u_cm1_r <= rd_data[2*HB-1:HB];
          state_r <= S_RD3;
        end
        S_RD3: begin
          m_cp1_r <= rd_data[HB-1:0];
          state_r <= S_WR;
        end
        S_WR: begin
          m_cm2_r <= rd_data[HB-1:0];
          slot_r  <= '0;
          state_r <= S_PICK;
        end
        S_PICK: begin
          if (found) begin
            pc_r        <= pc;
            pr_r        <= pr;
            run_end_r   <= last;
            frame_end_r <= (pr == r_last) && ({1'b0, pc} == w_last);
            slot_r      <= sel + 2'd1;
            state_r     <= S_NORM;
          end else begin
            prev_r  <= h_r;
            state_r <= S_IDLE;
          end
        end
        S_NORM: begin
          if (nres.done) begin
            out_nx_r <= nres.x;
            out_ny_r <= nres.y;
            out_nz_r <= nres.z;
            state_r  <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            out_column_r    <= pc_r;
            out_row_r       <= pr_r;
            out_normal_x    <= out_nx_r;
            out_normal_y    <= out_ny_r;
            out_normal_z    <= out_nz_r;
            out_run_end_r   <= run_end_r;
            out_frame_end_r <= frame_end_r;
            state_r         <= S_PICK;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall      = (state_r != S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_column    = out_column_r;
  assign out_row       = out_row_r;
  assign out_run_end   = out_run_end_r;
  assign out_frame_end = out_frame_end_r;

endmodule
